### sv/antialiased_circle_crop_defines.svh
// Assertion macros shared by the circle crop RTL.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef ANTIALIASED_CIRCLE_CROP_DEFINES_SVH
`define ANTIALIASED_CIRCLE_CROP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The condition must never be true outside reset.
`define ACC_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

### sv/acc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, widths and types of the circle crop pipeline.
// No dependencies; acc_front, acc_sqrt, acc_back and the top level import this package.
package acc_pkg;

  localparam int FRAC_BITS     = 8;
  localparam int MAX_IMAGE_DIM = 4096;
  localparam int MAX_CANVAS    = 16384;

  localparam int COORD_W  = 14;
  localparam int COLOR_W  = 8;
  localparam int POS_W    = 15;
  localparam int CFG_W    = 20;
  localparam int CANVAS_W = 14;
  localparam int DIM_W    = 13;
  localparam int IDX_W    = 3;

  localparam int HALF = 1 << (FRAC_BITS - 1);
  localparam int ONE  = 1 << FRAC_BITS;

  localparam int POS_MIN = -(1 << (POS_W - 1));
  localparam int POS_MAX = (1 << (POS_W - 1)) - 1;

  localparam logic [CANVAS_W-1:0] CANVAS_MASK = CANVAS_W'(MAX_CANVAS - 1);

  // Signed offset from the canvas center in half pixels, and its magnitude.
  localparam int H_W  = COORD_W + 3;
  localparam int U_W  = COORD_W + 2;
  localparam int SQ_W = 2 * U_W;

  // Square root pipeline: two result bits per stage.
  localparam int ROOT_W      = (SQ_W + 2 * FRAC_BITS) / 2;
  localparam int SQRT_STAGES = (ROOT_W + 1) / 2;
  localparam int ROOTP_W     = 2 * SQRT_STAGES;
  localparam int RADP_W      = 2 * ROOTP_W;
  localparam int REM_W       = ROOTP_W + 2;

  // Source position sum and its floored integer part.
  localparam int SUM_W = ((CFG_W + 1 > H_W + FRAC_BITS - 1) ? CFG_W + 1
                                                            : H_W + FRAC_BITS - 1) + 1;
  localparam int SC_W  = SUM_W - FRAC_BITS;

  localparam int COV_W  = FRAC_BITS + 1;
  localparam int DIFF_W = ((CFG_W > ROOTP_W) ? CFG_W : ROOTP_W) + 2;

  typedef enum logic [IDX_W-1:0] {
    REG_CENTER_X      = 3'd0,
    REG_CENTER_Y      = 3'd1,
    REG_CIRCLE_RADIUS = 3'd2,
    REG_CANVAS_SIZE   = 3'd3,
    REG_IMAGE_WIDTH   = 3'd4,
    REG_IMAGE_HEIGHT  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0]    crop_cx;
    logic [CFG_W-1:0]    crop_cy;
    logic [CFG_W-1:0]    circle_radius;
    logic [CANVAS_W-1:0] canvas_size;
    logic [DIM_W-1:0]    image_width;
    logic [DIM_W-1:0]    image_height;
  } cfg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] alpha;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } pix_t;

  // Per-pixel data that rides along the pipeline; also the result format.
  typedef struct packed {
    pix_t                    pix;
    logic signed [POS_W-1:0] src_col;
    logic signed [POS_W-1:0] src_row;
    logic                    in_bounds;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [SQ_W-1:0]  sum_sq;
  } front_t;

endpackage

### sv/acc_front.sv
`timescale 1ns / 1ps
// Front end: canvas offsets, source position, bounds test and squared distance.
// Three register stages; depends on acc_pkg.
module acc_front import acc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COORD_W-1:0] in_col,
  input  logic [COORD_W-1:0] in_row,
  input  pix_t               in_pix,
  output logic               out_valid,
  input  logic               out_ready,
  output front_t             out_data
);

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SC_W-1:0] v);
    if (v < $signed(SC_W'(POS_MIN))) begin
      return POS_W'(POS_MIN);
    end else if (v > $signed(SC_W'(POS_MAX))) begin
      return POS_W'(POS_MAX);
    end
    return POS_W'(v);
  endfunction

  function automatic logic signed [SC_W-1:0] dim_limit(input logic [DIM_W-1:0] d);
    if (32'(d) > MAX_IMAGE_DIM) begin
      return SC_W'(MAX_IMAGE_DIM);
    end
    return $signed(SC_W'(d));
  endfunction

  logic                  a_v_r, b_v_r, c_v_r;
  logic                  ld_a, ld_b, ld_c;
  logic [CANVAS_W-1:0]   size;
  logic signed [H_W-1:0] hx_nxt, hy_nxt;
  logic signed [H_W-1:0] a_hx_r, a_hy_r;
  pix_t                  a_pix_r;
  logic [U_W-1:0]        ux, uy;
  logic signed [SUM_W-1:0] sx, sy;
  logic signed [SC_W-1:0]  sc, sr;
  logic                  in_bounds;
  side_t                 side_nxt;
  logic [SQ_W-1:0]       b_ux2_r, b_uy2_r;
  side_t                 b_side_r;
  front_t                c_data_r;

  assign ld_c     = !c_v_r || out_ready;
  assign ld_b     = !b_v_r || ld_c;
  assign ld_a     = !a_v_r || ld_b;
  assign in_ready = ld_a;

  assign size   = cfg.canvas_size & CANVAS_MASK;
  assign hx_nxt = $signed({2'b00, in_col, 1'b1}) - $signed({3'b000, size});
  assign hy_nxt = $signed({2'b00, in_row, 1'b1}) - $signed({3'b000, size});

  always_comb begin
    ux = a_hx_r[H_W-1] ? U_W'(-a_hx_r) : U_W'(a_hx_r);
    uy = a_hy_r[H_W-1] ? U_W'(-a_hy_r) : U_W'(a_hy_r);
    sx = $signed(SUM_W'(cfg.crop_cx)) + (SUM_W'(a_hx_r) <<< (FRAC_BITS - 1));
    sy = $signed(SUM_W'(cfg.crop_cy)) + (SUM_W'(a_hy_r) <<< (FRAC_BITS - 1));
    sc = SC_W'(sx >>> FRAC_BITS);
    sr = SC_W'(sy >>> FRAC_BITS);
    in_bounds = !sc[SC_W-1] && !sr[SC_W-1] &&
                (sc < dim_limit(cfg.image_width)) && (sr < dim_limit(cfg.image_height));
    side_nxt.pix       = a_pix_r;
    side_nxt.src_col   = sat_pos(sc);
    side_nxt.src_row   = sat_pos(sr);
    side_nxt.in_bounds = in_bounds;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (ld_a) a_v_r <= in_valid;
      if (ld_b) b_v_r <= a_v_r;
      if (ld_c) c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_a) begin
      a_hx_r  <= hx_nxt;
      a_hy_r  <= hy_nxt;
      a_pix_r <= in_pix;
    end
    if (ld_b) begin
      b_ux2_r  <= ux * ux;
      b_uy2_r  <= uy * uy;
      b_side_r <= side_nxt;
    end
    if (ld_c) begin
      c_data_r.sum_sq <= b_ux2_r + b_uy2_r;
      c_data_r.side   <= b_side_r;
    end
  end

  assign out_valid = c_v_r;
  assign out_data  = c_data_r;

endmodule

### sv/acc_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root of the scaled squared distance.
// Two result bits per stage, side data carried along; depends on acc_pkg.
module acc_sqrt import acc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SQ_W-1:0]    in_sum,
  input  side_t              in_side,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ROOTP_W-1:0] out_root,
  output side_t              out_side
);

  localparam int Last = SQRT_STAGES - 1;

  typedef struct packed {
    logic [REM_W-1:0]   rem;
    logic [ROOTP_W-1:0] root;
  } sq_t;

  function automatic sq_t sq_iter(input sq_t s, input logic [1:0] two);
    sq_t              o;
    logic [REM_W-1:0] t_rem;
    logic [REM_W-1:0] trial;
    t_rem = {s.rem[REM_W-3:0], two};
    trial = {s.root, 2'b01};
    if (t_rem >= trial) begin
      o.rem  = t_rem - trial;
      o.root = {s.root[ROOTP_W-2:0], 1'b1};
    end else begin
      o.rem  = t_rem;
      o.root = {s.root[ROOTP_W-2:0], 1'b0};
    end
    return o;
  endfunction

  logic              v_r    [SQRT_STAGES];
  logic              ld     [SQRT_STAGES];
  sq_t               sq_r   [SQRT_STAGES];
  side_t             side_r [SQRT_STAGES];
  logic [RADP_W-1:0] rad_r  [SQRT_STAGES-1];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic              v_in;
    sq_t               sq_in;
    side_t             side_in;
    logic [RADP_W-1:0] rad_in;
    sq_t               sq_mid;
    sq_t               sq_nxt;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign sq_in   = '0;
      assign side_in = in_side;
      assign rad_in  = RADP_W'(in_sum) << (2 * FRAC_BITS);
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign sq_in   = sq_r[k-1];
      assign side_in = side_r[k-1];
      assign rad_in  = rad_r[k-1];
    end

    if (k == Last) begin : g_ld_last
      assign ld[k] = !v_r[k] || out_ready;
    end else begin : g_ld_mid
      assign ld[k] = !v_r[k] || ld[k+1];
      always_ff @(posedge clk) begin
        if (ld[k]) rad_r[k] <= rad_in << 4;
      end
    end

    assign sq_mid = sq_iter(sq_in, rad_in[RADP_W-1 -: 2]);
    assign sq_nxt = sq_iter(sq_mid, rad_in[RADP_W-3 -: 2]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ld[k]) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ld[k]) begin
        sq_r[k]   <= sq_nxt;
        side_r[k] <= side_in;
      end
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = v_r[Last];
  assign out_root  = sq_r[Last].root;
  assign out_side  = side_r[Last];

endmodule

### sv/acc_back.sv
`timescale 1ns / 1ps
// Back end: edge coverage from the root, alpha scaling and the output register.
// Two register stages; depends on acc_pkg.
module acc_back import acc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [CFG_W-1:0]   radius,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ROOTP_W-1:0] in_root,
  input  side_t              in_side,
  output logic               out_valid,
  input  logic               out_ready,
  output side_t              out_res
);

  logic                     d_v_r, e_v_r;
  logic                     ld_d, ld_e;
  logic [ROOTP_W-1:0]       half_root;
  logic signed [DIFF_W-1:0] diff;
  logic [COV_W-1:0]         cov_nxt;
  logic [COV_W-1:0]         d_cov_r;
  side_t                    d_side_r;
  logic [COLOR_W+COV_W-1:0] scaled;
  side_t                    res_nxt;
  side_t                    e_res_r;

  assign ld_e     = !e_v_r || out_ready;
  assign ld_d     = !d_v_r || ld_e;
  assign in_ready = ld_d;

  always_comb begin
    half_root = in_root >> 1;
    diff = $signed(DIFF_W'(radius)) - $signed(DIFF_W'(half_root)) + $signed(DIFF_W'(HALF));
    if (diff[DIFF_W-1]) begin
      cov_nxt = '0;
    end else if (diff > $signed(DIFF_W'(ONE))) begin
      cov_nxt = COV_W'(ONE);
    end else begin
      cov_nxt = diff[COV_W-1:0];
    end
  end

  always_comb begin
    scaled  = (COLOR_W+COV_W)'(d_side_r.pix.alpha) * (COLOR_W+COV_W)'(d_cov_r)
            + (COLOR_W+COV_W)'(HALF);
    res_nxt = d_side_r;
    if ((d_cov_r != '0) && d_side_r.in_bounds) begin
      res_nxt.pix.alpha = scaled[FRAC_BITS +: COLOR_W];
    end else begin
      res_nxt.pix = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
    end else begin
      if (ld_d) d_v_r <= in_valid;
      if (ld_e) e_v_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_d) begin
      d_cov_r  <= cov_nxt;
      d_side_r <= in_side;
    end
    if (ld_e) e_res_r <= res_nxt;
  end

  assign out_valid = e_v_r;
  assign out_res   = e_res_r;

endmodule

### sv/antialiased_circle_crop.sv
`timescale 1ns / 1ps
// Top level of the antialiased circular alpha mask, with the register file.
// Instantiates acc_front, acc_sqrt and acc_back; uses acc_pkg and the defines header.
`include "antialiased_circle_crop_defines.svh"

// One canvas pixel request enters per cycle while out_tready is high. The pipeline has
// 3 front stages, 12 square-root stages and 2 back stages; the square-root pipeline,
// which resolves two root bits per stage, is the deepest part. Every stage stalls
// only when the stage after it is full and blocked, so bubbles are squeezed out and
// the sustained rate stays at one pixel per cycle while out_tready is high. Registers
// are written through the configuration channel, which is always ready, and may only
// change while no pixel is in flight. No memory and no clearing pass after reset.
module antialiased_circle_crop import acc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_tvalid,
  output logic             in_tready,
  // out_col[13:0], out_row[27:14], src_red[35:28], src_green[43:36],
  // src_blue[51:44], src_alpha[59:52], zero fill above.
  input  logic [63:0]      in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // res_red[7:0], res_green[15:8], res_blue[23:16], res_alpha[31:24],
  // source_col[46:32], source_row[61:47], zero fill above.
  output logic [63:0]      out_tdata,
  // source_inside[0].
  output logic             out_tuser
);

  cfg_t               cfg_r;
  pix_t               in_pix;
  logic               f_valid, f_ready;
  front_t             f_data;
  logic               s_valid, s_ready;
  logic [ROOTP_W-1:0] s_root;
  side_t              s_side;
  side_t              res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.crop_cx       <= '0;
      cfg_r.crop_cy       <= '0;
      cfg_r.circle_radius <= '0;
      cfg_r.canvas_size   <= CANVAS_W'(1);
      cfg_r.image_width   <= DIM_W'(1);
      cfg_r.image_height  <= DIM_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CENTER_X:      cfg_r.crop_cx       <= cfg_data;
        REG_CENTER_Y:      cfg_r.crop_cy       <= cfg_data;
        REG_CIRCLE_RADIUS: cfg_r.circle_radius <= cfg_data;
        REG_CANVAS_SIZE:   cfg_r.canvas_size   <= cfg_data[CANVAS_W-1:0];
        REG_IMAGE_WIDTH:   cfg_r.image_width   <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT:  cfg_r.image_height  <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_pix.red   = in_tdata[35:28];
  assign in_pix.green = in_tdata[43:36];
  assign in_pix.blue  = in_tdata[51:44];
  assign in_pix.alpha = in_tdata[59:52];

  acc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_col    (in_tdata[13:0]),
    .in_row    (in_tdata[27:14]),
    .in_pix    (in_pix),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_data  (f_data)
  );

  acc_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_sum    (f_data.sum_sq),
    .in_side   (f_data.side),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_root  (s_root),
    .out_side  (s_side)
  );

  acc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .radius    (cfg_r.circle_radius),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .in_root   (s_root),
    .in_side   (s_side),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {2'b00, res.src_row, res.src_col,
                      res.pix.alpha, res.pix.blue, res.pix.green, res.pix.red};
  assign out_tuser = res.in_bounds;

  `ACC_ASSERT_IMP(a_alpha_needs_bounds, out_tvalid && (res.pix.alpha != '0), res.in_bounds, "nonzero alpha outside the image")
  `ACC_ASSERT_IMP(a_outside_is_clear, out_tvalid && !res.in_bounds, res.pix == '0, "pixel outside the image is not cleared")
  `ACC_ASSERT_IMP(a_bounds_nonneg, out_tvalid && res.in_bounds, !res.src_col[POS_W-1] && !res.src_row[POS_W-1], "in bounds with a negative position")
  `ACC_ASSERT_NEVER(a_stall_only_blocked, !in_tready && !(out_tvalid && !out_tready), "input stalled while the output is not blocked")

endmodule
